FILE: rtl/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types and codes of the schedule download tracker.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int MAX_CHUNKS = 32;

  // slot event opcodes
  localparam logic [1:0] OP_SLOT    = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_DESYNC  = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // configuration register indexes
  localparam logic CFG_REPS    = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // reported status codes
  localparam logic [2:0] ST_APPLIED    = 3'd0;
  localparam logic [2:0] ST_SENDING    = 3'd1;
  localparam logic [2:0] ST_PROCESSING = 3'd2;
  localparam logic [2:0] ST_AWAITING   = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;

  typedef enum logic [4:0] {
    PH_APPLIED    = 5'b00001,
    PH_SENDING    = 5'b00010,
    PH_PROCESSING = 5'b00100,
    PH_AWAITING   = 5'b01000,
    PH_INCOMPLETE = 5'b10000
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE       = 4'd0,
    ACT_INIT       = 4'd1,
    ACT_APPEND     = 4'd2,
    ACT_INFO       = 4'd3,
    ACT_SETNEW     = 4'd4,
    ACT_SETEMPTY   = 4'd5,
    ACT_SETSAME    = 4'd6,
    ACT_APPLYNEW   = 4'd7,
    ACT_APPLYEMPTY = 4'd8,
    ACT_APPLYSAME  = 4'd9,
    ACT_EXPAND     = 4'd10
  } action_t;

  typedef struct packed {
    logic        listened;
    logic [2:0]  status;
    action_t     action;
    logic        resend_request;
    logic        chunk_rejected;
    logic        protocol_error;
    logic        schedule_complete;
    logic [31:0] held_sched_id;
  } result_t;

endpackage

FILE: rtl/schedule_download_tracker_unit.sv
// ----------------------------------------------------------------------------
// schedule_download_tracker_unit
// Tracks a TDMA node's download of a multi-chunk schedule, one slot event
// per item, and reports listening, action, resend and error flags.
// ----------------------------------------------------------------------------
// Each accepted item (slot, advance, desync or no-op) yields exactly one
// result item. An item is taken in every cycle while in_stall is low: all
// tracker state (status, chunk flags, round counters, ids, activation tile,
// timeout counter) is updated by one pass of logic at the accept edge, so
// the next item sees the new state in the next cycle. Results leave through
// an output register backed by one skid register; in_stall is registered
// and rises only while both hold an undelivered result. Configuration writes
// are always ready and take effect for the next item; they are to be issued
// only while the block is idle.
module schedule_download_tracker_unit (
  input  logic        clk,
  input  logic        rst_n,
  // slot events
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_current_tile,
  input  logic        in_pkt_ok,
  input  logic        in_is_schedule,
  input  logic [31:0] in_sched_id,
  input  logic [5:0]  in_total_chunks,
  input  logic [4:0]  in_chunk_index,
  input  logic [3:0]  in_repetition,
  input  logic [31:0] in_activation_tile,
  input  logic [15:0] in_schedule_tiles,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_listened,
  output logic [2:0]  out_status,
  output logic [3:0]  out_action,
  output logic        out_resend_request,
  output logic        out_chunk_rejected,
  output logic        out_protocol_error,
  output logic        out_schedule_complete,
  output logic [31:0] out_held_sched_id,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import sdt_pkg::*;

  // configuration
  logic [3:0]  reps_r;
  logic [15:0] tmo_limit_r;

  // tracker state
  phase_t                phase_r, phase_nxt;
  logic [MAX_CHUNKS-1:0] seen_r, seen_nxt;
  logic [5:0]            count_r, count_nxt;
  logic [31:0]           hdr_id_r, hdr_id_nxt;
  logic [31:0]           hdr_act_r, hdr_act_nxt;
  logic [15:0]           hdr_tiles_r, hdr_tiles_nxt;
  logic [9:0]            rounds_total_r, rounds_total_nxt;
  logic [9:0]            rounds_done_r, rounds_done_nxt;
  logic [31:0]           cur_id_r, cur_id_nxt;
  logic [31:0]           last_id_r, last_id_nxt;
  logic [31:0]           next_act_r, next_act_nxt;
  logic [15:0]           tmo_r, tmo_nxt;

  // output register and skid
  result_t out_r, skid_r, res;
  logic    out_valid_r, skid_valid_r;
  logic    accept, out_take;

  // scratch for the update pass
  logic        skip_rx;
  logic        got;
  logic        geom_ok;
  logic        cur_newer;
  logic        complete_now;
  logic [15:0] tick;
  logic [9:0]  prod_total;
  logic [9:0]  prod_rep;

  function automatic logic chunks_complete(input logic [5:0] cnt,
                                           input logic [MAX_CHUNKS-1:0] seen);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      if (i < int'(cnt)) ok = ok & seen[i];
    end
    return (cnt != 6'd0) && ok;
  endfunction

  function automatic logic [2:0] status_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_APPLIED:    code = ST_APPLIED;
      PH_SENDING:    code = ST_SENDING;
      PH_PROCESSING: code = ST_PROCESSING;
      PH_AWAITING:   code = ST_AWAITING;
      PH_INCOMPLETE: code = ST_INCOMPLETE;
      default:       code = ST_APPLIED;
    endcase
    return code;
  endfunction

  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;

  // header products for a fresh schedule, truncated to the round width
  assign prod_total = {4'd0, in_total_chunks} * {6'd0, reps_r};
  assign prod_rep   = {6'd0, in_repetition} * {6'd0, reps_r};
  assign cur_newer  = cur_id_r > last_id_r;
  assign complete_now = chunks_complete(count_r, seen_r);
  assign geom_ok = (in_total_chunks != 6'd0) &&
                   ({26'd0, in_total_chunks} <= 32'(MAX_CHUNKS)) &&
                   ({1'b0, in_chunk_index} < in_total_chunks);
  assign tick = tmo_r + 16'd1;

  // one update pass per item
  always_comb begin
    phase_nxt        = phase_r;
    seen_nxt         = seen_r;
    count_nxt        = count_r;
    hdr_id_nxt       = hdr_id_r;
    hdr_act_nxt      = hdr_act_r;
    hdr_tiles_nxt    = hdr_tiles_r;
    rounds_total_nxt = rounds_total_r;
    rounds_done_nxt  = rounds_done_r;
    cur_id_nxt       = cur_id_r;
    last_id_nxt      = last_id_r;
    next_act_nxt     = next_act_r;
    tmo_nxt          = tmo_r;
    res              = '0;
    res.action       = ACT_NONE;
    skip_rx          = 1'b0;
    got              = 1'b0;

    // slot preamble: end of sending, activation checks
    if (in_opcode == OP_SLOT || in_opcode == OP_ADVANCE) begin
      case (phase_r)
        PH_SENDING: begin
          if (rounds_done_r >= rounds_total_r) begin
            next_act_nxt = hdr_act_r;
            if (cur_newer) begin
              if (complete_now) begin
                res.action = ACT_SETNEW;
              end else begin
                tmo_nxt            = '0;
                res.resend_request = 1'b1;
                res.action         = ACT_SETEMPTY;
              end
            end else begin
              res.action = ACT_SETSAME;
            end
            phase_nxt = PH_PROCESSING;
            skip_rx   = 1'b1;
          end
        end
        PH_PROCESSING, PH_AWAITING: begin
          if (in_current_tile >= next_act_r) begin
            // activation
            if (cur_newer) begin
              if (complete_now) begin
                last_id_nxt = cur_id_r;
                phase_nxt   = PH_APPLIED;
                res.action  = ACT_APPLYNEW;
              end else begin
                phase_nxt     = PH_INCOMPLETE;
                hdr_id_nxt    = '0;
                hdr_act_nxt   = '0;
                hdr_tiles_nxt = '0;
                count_nxt     = '0;
                seen_nxt      = '0;
                res.action    = ACT_APPLYEMPTY;
              end
            end else begin
              phase_nxt  = PH_APPLIED;
              res.action = ACT_APPLYSAME;
            end
            skip_rx = 1'b1;
          end else if (phase_r == PH_PROCESSING) begin
            if (complete_now) res.action = ACT_EXPAND;
            phase_nxt = PH_AWAITING;
            skip_rx   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (in_opcode == OP_DESYNC) begin
      hdr_id_nxt    = '0;
      hdr_act_nxt   = '0;
      hdr_tiles_nxt = '0;
      count_nxt     = '0;
      seen_nxt      = '0;
      tmo_nxt       = '0;
      last_id_nxt   = '0;
      cur_id_nxt    = '0;
      next_act_nxt  = '0;
      phase_nxt     = PH_APPLIED;
    end else if (in_opcode == OP_SLOT && !skip_rx) begin
      res.listened = 1'b1;
      // a schedule chunk with bad geometry counts as nothing received
      got = in_pkt_ok && (!in_is_schedule || geom_ok);
      if (got) begin
        case (phase_r)
          PH_APPLIED, PH_INCOMPLETE, PH_SENDING: begin
            if (in_is_schedule) begin
              if (phase_r == PH_SENDING && in_sched_id == hdr_id_r) begin
                res.action = ACT_APPEND;
                if (in_total_chunks != count_r || in_schedule_tiles != hdr_tiles_r ||
                    in_activation_tile != hdr_act_r) begin
                  res.chunk_rejected = 1'b1;
                end else begin
                  seen_nxt[in_chunk_index] = 1'b1;
                end
                rounds_done_nxt = rounds_done_r + 10'd1;
              end else begin
                // fresh schedule header
                hdr_id_nxt       = in_sched_id;
                hdr_act_nxt      = in_activation_tile;
                hdr_tiles_nxt    = in_schedule_tiles;
                count_nxt        = in_total_chunks;
                seen_nxt         = '0;
                seen_nxt[in_chunk_index] = 1'b1;
                cur_id_nxt       = in_sched_id;
                rounds_total_nxt = prod_total;
                rounds_done_nxt  = 10'd1 + prod_rep + {5'd0, in_chunk_index};
                res.action       = ACT_INIT;
                phase_nxt        = PH_SENDING;
              end
            end else if (phase_r != PH_SENDING) begin
              // info packets are ignored while sending
              res.action = ACT_INFO;
              if (phase_r == PH_INCOMPLETE) begin
                tmo_nxt = tick;
                if (tick >= tmo_limit_r) begin
                  tmo_nxt            = '0;
                  res.resend_request = 1'b1;
                end
              end
            end
          end
          PH_AWAITING: begin
            if (in_is_schedule) res.protocol_error = 1'b1;
            else res.action = ACT_INFO;
          end
          default: begin
          end
        endcase
      end else if (phase_r == PH_INCOMPLETE) begin
        tmo_nxt = tick;
        if (tick >= tmo_limit_r) begin
          tmo_nxt            = '0;
          res.resend_request = 1'b1;
        end
      end else if (phase_r == PH_SENDING) begin
        rounds_done_nxt = rounds_done_r + 10'd1;
      end
    end

    res.status            = status_code(phase_nxt);
    res.schedule_complete = chunks_complete(count_nxt, seen_nxt);
    res.held_sched_id     = cur_id_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reps_r      <= 4'd1;
      tmo_limit_r <= 16'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REPS:    reps_r      <= cfg_data[3:0];
        CFG_TIMEOUT: tmo_limit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_APPLIED;
      seen_r         <= '0;
      count_r        <= '0;
      hdr_id_r       <= '0;
      hdr_act_r      <= '0;
      hdr_tiles_r    <= '0;
      rounds_total_r <= '0;
      rounds_done_r  <= '0;
      cur_id_r       <= '0;
      last_id_r      <= '0;
      next_act_r     <= '0;
      tmo_r          <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      seen_r         <= seen_nxt;
      count_r        <= count_nxt;
      hdr_id_r       <= hdr_id_nxt;
      hdr_act_r      <= hdr_act_nxt;
      hdr_tiles_r    <= hdr_tiles_nxt;
      rounds_total_r <= rounds_total_nxt;
      rounds_done_r  <= rounds_done_nxt;
      cur_id_r       <= cur_id_nxt;
      last_id_r      <= last_id_nxt;
      next_act_r     <= next_act_nxt;
      tmo_r          <= tmo_nxt;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) skid_valid_r <= 1'b0;
    end else if (accept) begin
      if (out_valid_r && !out_take) skid_valid_r <= 1'b1;
      else out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) out_r <= skid_r;
    end else if (accept) begin
      if (out_valid_r && !out_take) skid_r <= res;
      else out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_listened          = out_r.listened;
  assign out_status            = out_r.status;
  assign out_action            = out_r.action;
  assign out_resend_request    = out_r.resend_request;
  assign out_chunk_rejected    = out_r.chunk_rejected;
  assign out_protocol_error    = out_r.protocol_error;
  assign out_schedule_complete = out_r.schedule_complete;
  assign out_held_sched_id     = out_r.held_sched_id;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_resend_cause: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.resend_request |->
      (res.status == ST_INCOMPLETE || res.action == ACT_SETEMPTY))
    else $error("resend request outside incomplete status");

  a_perr_awaiting: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.protocol_error |-> res.status == ST_AWAITING && res.listened)
    else $error("protocol error outside awaiting status");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    {26'd0, count_r} <= 32'(MAX_CHUNKS))
    else $error("chunk count beyond maximum");

endmodule

FILE: dv/tb_schedule_download_tracker_unit.sv
// ----------------------------------------------------------------------------
// tb_schedule_download_tracker_unit
// Self-checking bench for the schedule download tracker. Slot events are
// driven with random gaps and the result channel is stalled at random. Every
// accepted item runs through a behavioral tracker model kept here, and each
// result is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_schedule_download_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sdt_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 8;

  // one slot event as the tracker sees it
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] tile;
    logic        pkt_ok;
    logic        is_sched;
    logic [31:0] sched_id;
    logic [5:0]  total;
    logic [4:0]  idx;
    logic [3:0]  rep;
    logic [31:0] act_tile;
    logic [15:0] tiles;
  } slot_evt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_NOP;
  logic [31:0] in_current_tile = '0;
  logic        in_pkt_ok = 1'b0;
  logic        in_is_schedule = 1'b0;
  logic [31:0] in_sched_id = '0;
  logic [5:0]  in_total_chunks = '0;
  logic [4:0]  in_chunk_index = '0;
  logic [3:0]  in_repetition = '0;
  logic [31:0] in_activation_tile = '0;
  logic [15:0] in_schedule_tiles = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_listened;
  logic [2:0]  out_status;
  logic [3:0]  out_action;
  logic        out_resend_request;
  logic        out_chunk_rejected;
  logic        out_protocol_error;
  logic        out_schedule_complete;
  logic [31:0] out_held_sched_id;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_REPS;
  logic [15:0] cfg_data = '0;

  // run bookkeeping
  result_t     expected_results[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;
  logic [31:0] cur_tile = '0;

  // tracker model state and its copy of the registers
  logic [3:0]  cfg_reps;
  logic [15:0] cfg_timeout;
  logic [2:0]  trk_status;
  logic [31:0] trk_seen;
  logic [5:0]  trk_count;
  logic [31:0] trk_hdr_id;
  logic [31:0] trk_hdr_act;
  logic [15:0] trk_hdr_tiles;
  logic [9:0]  trk_rounds_target;
  logic [9:0]  trk_rounds_done;
  logic [31:0] trk_cur_id;
  logic [31:0] trk_last_id;
  logic [31:0] trk_next_act;
  logic [15:0] trk_idle_slots;
  action_t     trk_act;
  logic        trk_resend;

  schedule_download_tracker_unit u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_current_tile       (in_current_tile),
    .in_pkt_ok             (in_pkt_ok),
    .in_is_schedule        (in_is_schedule),
    .in_sched_id           (in_sched_id),
    .in_total_chunks       (in_total_chunks),
    .in_chunk_index        (in_chunk_index),
    .in_repetition         (in_repetition),
    .in_activation_tile    (in_activation_tile),
    .in_schedule_tiles     (in_schedule_tiles),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_listened          (out_listened),
    .out_status            (out_status),
    .out_action            (out_action),
    .out_resend_request    (out_resend_request),
    .out_chunk_rejected    (out_chunk_rejected),
    .out_protocol_error    (out_protocol_error),
    .out_schedule_complete (out_schedule_complete),
    .out_held_sched_id     (out_held_sched_id),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tracker model
  // --------------------------------------------------------------------------
  function automatic logic trk_complete();
    logic [32:0] m;
    if (trk_count == 6'd0) return 1'b0;
    m = (33'd1 << trk_count) - 33'd1;
    return ({1'b0, trk_seen} & m) == m;
  endfunction

  function automatic void trk_clear_header();
    trk_hdr_id = '0;
    trk_hdr_act = '0;
    trk_hdr_tiles = '0;
    trk_count = '0;
    trk_seen = '0;
  endfunction

  function automatic void trk_reset();
    cfg_reps = 4'd1;
    cfg_timeout = 16'd64;
    trk_status = ST_APPLIED;
    trk_clear_header();
    trk_rounds_target = '0;
    trk_rounds_done = '0;
    trk_cur_id = '0;
    trk_last_id = '0;
    trk_next_act = '0;
    trk_idle_slots = '0;
  endfunction

  // activation tile reached: apply, or fall back to incomplete
  function automatic void trk_activate();
    if (trk_cur_id > trk_last_id) begin
      if (trk_complete()) begin
        trk_last_id = trk_cur_id;
        trk_status = ST_APPLIED;
        trk_act = ACT_APPLYNEW;
      end else begin
        trk_status = ST_INCOMPLETE;
        trk_clear_header();
        trk_act = ACT_APPLYEMPTY;
      end
    end else begin
      trk_status = ST_APPLIED;
      trk_act = ACT_APPLYSAME;
    end
  endfunction

  // work done ahead of the slot; returns 1 when the node does not listen
  function automatic logic trk_pre_slot(input logic [31:0] tile);
    logic skip;
    skip = 1'b0;
    case (trk_status)
      ST_SENDING: begin
        if (trk_rounds_done >= trk_rounds_target) begin
          trk_next_act = trk_hdr_act;
          if (trk_cur_id > trk_last_id) begin
            if (trk_complete()) begin
              trk_act = ACT_SETNEW;
            end else begin
              trk_idle_slots = '0;
              trk_resend = 1'b1;
              trk_act = ACT_SETEMPTY;
            end
          end else begin
            trk_act = ACT_SETSAME;
          end
          trk_status = ST_PROCESSING;
          skip = 1'b1;
        end
      end
      ST_PROCESSING: begin
        if (tile >= trk_next_act) begin
          trk_activate();
        end else begin
          if (trk_complete()) trk_act = ACT_EXPAND;
          trk_status = ST_AWAITING;
        end
        skip = 1'b1;
      end
      ST_AWAITING: begin
        if (tile >= trk_next_act) begin
          trk_activate();
          skip = 1'b1;
        end
      end
      default: ;
    endcase
    return skip;
  endfunction

  function automatic void trk_tick();
    trk_idle_slots = trk_idle_slots + 16'd1;
    if (trk_idle_slots >= cfg_timeout) begin
      trk_idle_slots = '0;
      trk_resend = 1'b1;
    end
  endfunction

  // first chunk of a schedule: latch its header
  function automatic void trk_load(input slot_evt_t e);
    int prod;
    trk_hdr_id = e.sched_id;
    trk_hdr_act = e.act_tile;
    trk_hdr_tiles = e.tiles;
    trk_count = e.total;
    trk_seen = 32'd1 << e.idx;
    trk_cur_id = e.sched_id;
    prod = int'(e.total) * int'(cfg_reps);
    trk_rounds_target = prod[9:0];
    prod = 1 + int'(e.rep) * int'(cfg_reps) + int'(e.idx);
    trk_rounds_done = prod[9:0];
    trk_act = ACT_INIT;
  endfunction

  function automatic result_t predict_tracker(input slot_evt_t e);
    result_t r;
    logic    heard;
    logic    got;
    logic    rejected;
    logic    perr;
    heard = 1'b0;
    rejected = 1'b0;
    perr = 1'b0;
    trk_act = ACT_NONE;
    trk_resend = 1'b0;
    case (e.opcode)
      OP_ADVANCE: void'(trk_pre_slot(e.tile));
      OP_DESYNC: begin
        trk_clear_header();
        trk_idle_slots = '0;
        trk_last_id = '0;
        trk_cur_id = '0;
        trk_next_act = '0;
        trk_status = ST_APPLIED;
      end
      OP_SLOT: begin
        if (!trk_pre_slot(e.tile)) begin
          heard = 1'b1;
          got = e.pkt_ok;
          // bad geometry counts as nothing received
          if (got && e.is_sched &&
              (e.total == 6'd0 || e.total > MAX_CHUNKS || {1'b0, e.idx} >= e.total))
            got = 1'b0;
          if (got) begin
            case (trk_status)
              ST_APPLIED: begin
                if (e.is_sched) begin
                  trk_load(e);
                  trk_status = ST_SENDING;
                end else begin
                  trk_act = ACT_INFO;
                end
              end
              ST_SENDING: begin
                if (e.is_sched) begin
                  if (e.sched_id != trk_hdr_id) begin
                    trk_load(e);
                  end else begin
                    trk_act = ACT_APPEND;
                    if (e.total != trk_count || e.tiles != trk_hdr_tiles ||
                        e.act_tile != trk_hdr_act)
                      rejected = 1'b1;
                    else
                      trk_seen = trk_seen | (32'd1 << e.idx);
                    trk_rounds_done = trk_rounds_done + 10'd1;
                  end
                end
              end
              ST_AWAITING: begin
                if (e.is_sched) perr = 1'b1;
                else trk_act = ACT_INFO;
              end
              ST_INCOMPLETE: begin
                if (e.is_sched) begin
                  trk_load(e);
                  trk_status = ST_SENDING;
                end else begin
                  trk_act = ACT_INFO;
                  trk_tick();
                end
              end
              default: ;
            endcase
          end else if (trk_status == ST_INCOMPLETE) begin
            trk_tick();
          end else if (trk_status == ST_SENDING) begin
            trk_rounds_done = trk_rounds_done + 10'd1;
          end
        end
      end
      default: ;
    endcase
    r.listened = heard;
    r.status = trk_status;
    r.action = trk_act;
    r.resend_request = trk_resend;
    r.chunk_rejected = rejected;
    r.protocol_error = perr;
    r.schedule_complete = trk_complete();
    r.held_sched_id = trk_cur_id;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake helpers
  // --------------------------------------------------------------------------
  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic slot_evt_t slot_evt(input logic [1:0] op, input logic [31:0] tile,
                                         input logic ok, input logic sch,
                                         input logic [31:0] id, input logic [5:0] total,
                                         input logic [4:0] idx, input logic [3:0] rep,
                                         input logic [31:0] act, input logic [15:0] tiles);
    slot_evt_t e;
    e.opcode = op;
    e.tile = tile;
    e.pkt_ok = ok;
    e.is_sched = sch;
    e.sched_id = id;
    e.total = total;
    e.idx = idx;
    e.rep = rep;
    e.act_tile = act;
    e.tiles = tiles;
    return e;
  endfunction

  // Drive one item, hold it through any stall, predict on acceptance.
  task automatic send_evt(input slot_evt_t e);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= e.opcode;
    in_current_tile <= e.tile;
    in_pkt_ok <= e.pkt_ok;
    in_is_schedule <= e.is_sched;
    in_sched_id <= e.sched_id;
    in_total_chunks <= e.total;
    in_chunk_index <= e.idx;
    in_repetition <= e.rep;
    in_activation_tile <= e.act_tile;
    in_schedule_tiles <= e.tiles;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_tracker(e));
    items_sent++;
    if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_REPS) cfg_reps = value[3:0];
    else cfg_timeout = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] reps, input logic [15:0] timeout_slots);
    logic [11:0] junk;
    junk = 12'($urandom);
    wait_idle();
    // upper data bits are don't-care for the 4-bit register
    write_reg(CFG_REPS, {junk, reps});
    write_reg(CFG_TIMEOUT, timeout_slots);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send_noise();
    slot_evt_t e;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) e.opcode = OP_SLOT;
    else if (pick < 15) e.opcode = OP_ADVANCE;
    else if (pick < 17) e.opcode = OP_DESYNC;
    else e.opcode = OP_NOP;
    e.tile = ($urandom_range(0, 1) == 0) ? $urandom : cur_tile;
    e.pkt_ok = 1'($urandom_range(0, 1));
    e.is_sched = 1'($urandom_range(0, 1));
    e.sched_id = ($urandom_range(0, 1) == 0) ? $urandom : trk_hdr_id;
    e.total = 6'($urandom_range(0, 63));
    e.idx = 5'($urandom);
    e.rep = 4'($urandom);
    e.act_tile = $urandom;
    e.tiles = 16'($urandom);
    send_evt(e);
    cur_tile = cur_tile + 32'd1;
  endtask

  // One schedule sent chunk by chunk with random drops and damage, then the
  // slots that carry it through setting and activation.
  task automatic run_download();
    slot_evt_t base;
    slot_evt_t c;
    int total;
    int rounds;
    int sent;
    int k;
    logic [31:0] id;
    if ($urandom_range(0, 15) == 0) cur_tile = $urandom;
    total = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 32) : $urandom_range(1, 4);
    rounds = (cfg_reps == 4'd0) ? 1 : int'(cfg_reps);
    case ($urandom_range(0, 5))
      0: id = trk_last_id;
      1: id = $urandom;
      default: id = trk_last_id + $urandom_range(1, 3);
    endcase
    base = slot_evt(OP_SLOT, cur_tile, 1'b1, 1'b1, id, total[5:0], 5'd0, 4'd0,
                    cur_tile + $urandom_range(0, total * rounds + 10), 16'($urandom));
    sent = 0;
    for (int r = 0; r < rounds; r++) begin
      for (int i = 0; i < total; i++) begin
        if (sent < 48) begin
          c = base;
          c.tile = cur_tile;
          c.idx = 5'(i);
          c.rep = 4'(r);
          c.pkt_ok = ($urandom_range(0, 11) != 0);
          case ($urandom_range(0, 39))
            0: c.tiles = c.tiles ^ 16'h0001;
            1: c.act_tile = c.act_tile + 32'd1;
            2: c.sched_id = $urandom;
            3: c.is_sched = 1'b0;
            default: ;
          endcase
          send_evt(c);
          cur_tile = cur_tile + 32'd1;
          sent++;
        end
      end
    end
    // carry the schedule to activation
    k = 0;
    while (k < 60 && trk_status != ST_APPLIED && trk_status != ST_INCOMPLETE) begin
      if ($urandom_range(0, 3) == 0)
        cur_tile = (trk_status == ST_SENDING) ? base.act_tile : trk_next_act;
      c = base;
      c.tile = cur_tile;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: c.opcode = OP_ADVANCE;
        6, 7, 8, 9, 10, 11: c.pkt_ok = 1'b0;
        12, 13, 14, 15, 16: c.is_sched = 1'b0;
        default: c.pkt_ok = 1'b1;
      endcase
      send_evt(c);
      cur_tile = cur_tile + 32'd1;
      k++;
    end
    // an incomplete schedule counts idle slots toward a resend
    if (trk_status == ST_INCOMPLETE) begin
      repeat ($urandom_range(0, 12)) begin
        c = base;
        c.tile = cur_tile;
        c.pkt_ok = 1'($urandom_range(0, 1));
        c.is_sched = 1'b0;
        send_evt(c);
        cur_tile = cur_tile + 32'd1;
      end
    end
    if ($urandom_range(0, 9) == 0)
      send_evt(slot_evt(OP_DESYNC, cur_tile, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // no-op with every field busy, then the quiet cases in applied
    send_evt(slot_evt(OP_NOP, 32'd100, 1'b1, 1'b1, 32'hA5A5_5A5A, 6'd63, 5'd31, 4'd15,
                      '1, '1));
    send_evt(slot_evt(OP_SLOT, 32'd100, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0));
    send_evt(slot_evt(OP_SLOT, 32'd101, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    // bad chunk geometry: zero chunks, too many chunks, index out of range
    send_evt(slot_evt(OP_SLOT, 32'd102, 1'b1, 1'b1, 32'd5, 6'd0, 5'd0, 4'd0, 32'd110, 16'd7));
    send_evt(slot_evt(OP_SLOT, 32'd102, 1'b1, 1'b1, 32'd5, 6'd33, 5'd0, 4'd0, 32'd110, 16'd7));
    send_evt(slot_evt(OP_SLOT, 32'd102, 1'b1, 1'b1, 32'd5, 6'd2, 5'd5, 4'd0, 32'd110, 16'd7));
    // two-chunk schedule, second chunk damaged: set empty with resend
    send_evt(slot_evt(OP_SLOT, 32'd102, 1'b1, 1'b1, 32'd5, 6'd2, 5'd0, 4'd0, 32'd110, 16'd7));
    send_evt(slot_evt(OP_SLOT, 32'd103, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0));
    send_evt(slot_evt(OP_SLOT, 32'd104, 1'b1, 1'b1, 32'd5, 6'd2, 5'd1, 4'd0, 32'd110, 16'd8));
    send_evt(slot_evt(OP_SLOT, 32'd105, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    send_evt(slot_evt(OP_SLOT, 32'd106, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    // awaiting: schedule packet is a protocol error, info is fine
    send_evt(slot_evt(OP_SLOT, 32'd107, 1'b1, 1'b1, 32'd5, 6'd2, 5'd1, 4'd0, 32'd110, 16'd7));
    send_evt(slot_evt(OP_SLOT, 32'd108, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0));
    send_evt(slot_evt(OP_ADVANCE, 32'd110, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    send_evt(slot_evt(OP_SLOT, 32'd111, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0));
    // single chunk from incomplete, set and applied
    send_evt(slot_evt(OP_SLOT, 32'd112, 1'b1, 1'b1, 32'd6, 6'd1, 5'd0, 4'd0, 32'd120, 16'd3));
    send_evt(slot_evt(OP_SLOT, 32'd113, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    send_evt(slot_evt(OP_ADVANCE, 32'd120, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    // widest header, already past its round count: the next slot sets it empty with resend
    send_evt(slot_evt(OP_SLOT, 32'd121, 1'b1, 1'b1, '1, 6'd32, 5'd31, 4'd15, '1, '1));
    send_evt(slot_evt(OP_SLOT, 32'd122, 1'b1, 1'b1, 32'd9, 6'd1, 5'd0, 4'd0, 32'd200, 16'd5));
    send_evt(slot_evt(OP_SLOT, 32'd123, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    send_evt(slot_evt(OP_SLOT, 32'd124, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    send_evt(slot_evt(OP_ADVANCE, 32'd200, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    // schedule packet while still awaiting is a protocol error, then advances and desync
    send_evt(slot_evt(OP_SLOT, 32'd201, 1'b1, 1'b1, 32'd9, 6'd1, 5'd0, 4'd0, 32'd202, 16'd5));
    send_evt(slot_evt(OP_ADVANCE, 32'd202, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    send_evt(slot_evt(OP_ADVANCE, 32'd203, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    send_evt(slot_evt(OP_DESYNC, 32'd204, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0));
    cur_tile = 32'd300;
  endtask

  // downloads with drops, damage and noise under several register settings, extremes included
  task automatic test_downloads();
    logic [3:0]  reps_list[5];
    logic [15:0] tmo_list[5];
    int target;
    reps_list = '{4'd1, 4'd2, 4'd15, 4'd3, 4'd0};
    tmo_list = '{16'd1, 16'd5, 16'hFFFF, 16'd0, 16'd0};
    tmo_list[3] = 16'($urandom_range(2, 40));
    for (int p = 0; p < 5; p++) begin
      set_config(reps_list[p], tmo_list[p]);
      target = items_sent + 220;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6)) send_noise();
        else run_download();
      end
    end
  endtask

  // unstructured items across every field value
  task automatic test_noise();
    set_config(4'($urandom_range(1, 15)), 16'($urandom_range(1, 65535)));
    repeat (300) send_noise();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall and comparison
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sink_stall
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      n = (out_valid && !out_stall) ? draw_wait() : stall_left;
      if (n > 0) begin
        out_stall <= 1'b1;
        stall_left <= n - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, status %0d action %0d", $time, out_status,
                 out_action);
      end else begin
        want = expected_results.pop_front();
        check_field("listened", 32'(want.listened), 32'(out_listened));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("action", 32'(want.action), 32'(out_action));
        check_field("resend_request", 32'(want.resend_request), 32'(out_resend_request));
        check_field("chunk_rejected", 32'(want.chunk_rejected), 32'(out_chunk_rejected));
        check_field("protocol_error", 32'(want.protocol_error), 32'(out_protocol_error));
        check_field("schedule_complete", 32'(want.schedule_complete),
                    32'(out_schedule_complete));
        check_field("held_sched_id", want.held_sched_id, out_held_sched_id);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    trk_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_downloads();
    test_noise();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
